/* rtl/utf8d_pkg.sv */
// Package for the UTF-8 byte stream decoder: status codes, automaton states,
// byte class table and state transition table.
// No dependencies.
`default_nettype none

package utf8d_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_INCOMPLETE = 2'd0,
    STAT_COMPLETE   = 2'd1,
    STAT_ERROR      = 2'd2
  } status_t;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned NUM_STATES  = 9;
  localparam int unsigned NUM_CLASSES = 12;

  localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
  localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [5:0]      CONT_MASK      = 6'h3F;
  localparam logic [7:0]      LEAD_MASK      = 8'hFF;

  // Transition table, rows are states, columns are byte classes
  localparam logic [STATE_W-1:0] NEXT_ST [NUM_STATES][NUM_CLASSES] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  // Map a raw byte to its character class
  function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
    logic [CLASS_W-1:0] cls;
    case (b) inside
      [8'h00:8'h7F]: cls = 4'd0;
      [8'h80:8'h8F]: cls = 4'd1;
      [8'h90:8'h9F]: cls = 4'd9;
      [8'hA0:8'hBF]: cls = 4'd7;
      8'hC0, 8'hC1:  cls = 4'd8;
      [8'hC2:8'hDF]: cls = 4'd2;
      8'hE0:         cls = 4'd10;
      8'hED:         cls = 4'd4;
      [8'hE1:8'hEF]: cls = 4'd3;
      8'hF0:         cls = 4'd11;
      [8'hF1:8'hF3]: cls = 4'd6;
      8'hF4:         cls = 4'd5;
      default:       cls = 4'd8;
    endcase
    return cls;
  endfunction

  // Next automaton state; codes past the table lead to reject
  function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] st,
                                                    input logic [CLASS_W-1:0] cls);
    logic [STATE_W-1:0] nst;
    if (st < STATE_W'(NUM_STATES) && cls < CLASS_W'(NUM_CLASSES)) begin
      nst = NEXT_ST[st][cls];
    end else begin
      nst = ST_REJECT;
    end
    return nst;
  endfunction

  // Outcome of one decode step
  typedef struct packed {
    status_t           status;
    logic [CP_W-1:0]    code_point;
    logic [STATE_W-1:0] state_nxt;
    logic [CP_W-1:0]    acc_nxt;
  } step_res_t;

endpackage

`default_nettype wire

/* rtl/utf8d_step.sv */
// Combinational decode step: classifies one byte, advances the automaton
// and assembles the code point. Depends on utf8d_pkg.
`default_nettype none

module utf8d_step
  import utf8d_pkg::*;
(
  input  wire logic [BYTE_W-1:0]  byte_i,
  input  wire logic [STATE_W-1:0] state_i,
  input  wire logic [CP_W-1:0]    acc_i,
  output step_res_t               res_o
);

  logic [CLASS_W-1:0] cls;
  logic [STATE_W-1:0] nst;
  logic [CP_W-1:0]    acc_new;
  logic [7:0]         lead_bits;

  // Classify and look up the transition
  assign cls = byte_class(byte_i);
  assign nst = next_state(state_i, cls);

  // Lead byte keeps its payload bits, continuation appends six bits
  assign lead_bits = (LEAD_MASK >> cls) & byte_i;

  always_comb begin
    if (state_i != ST_ACCEPT) begin
      acc_new = {acc_i[CP_W-7:0], byte_i[5:0] & CONT_MASK};
    end else begin
      acc_new = {{(CP_W-8){1'b0}}, lead_bits};
    end
  end

  // Form the result and the state left behind
  always_comb begin
    if (nst == ST_ACCEPT) begin
      res_o.status     = STAT_COMPLETE;
      res_o.code_point = acc_new;
      res_o.state_nxt  = ST_ACCEPT;
      res_o.acc_nxt    = acc_new;
    end else if (nst == ST_REJECT) begin
      res_o.status     = STAT_ERROR;
      res_o.code_point = CP_REPLACEMENT;
      res_o.state_nxt  = ST_ACCEPT;
      res_o.acc_nxt    = '0;
    end else begin
      res_o.status     = STAT_INCOMPLETE;
      res_o.code_point = '0;
      res_o.state_nxt  = nst;
      res_o.acc_nxt    = acc_new;
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8_byte_stream_decoder.sv */
// UTF-8 byte stream decoder, top level: input register, decode step and
// result register. Depends on utf8d_pkg and utf8d_step.
`default_nettype none

// Accepts one UTF-8 byte per cycle and returns exactly one result item per
// byte: status complete with the code point, status error with U+FFFD (the
// bad byte is consumed and decoding restarts), or status incomplete with a
// zero code point. Throughput is one item per cycle while the result side
// does not stall, set by the update of the automaton state and code point
// registers. A byte is held in the input register, decoded, and its result
// is stored in the result register until accepted. Back-pressure on the
// result side stalls the input register, which then deasserts in_tready.
module utf8_byte_stream_decoder
  import utf8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] in_byte
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: [20:0] code_point, [23:21] zero
  output logic [23:0]      out_tdata,
  // out_tuser: [1:0] status
  output logic [1:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic [STATE_W-1:0] dfa_state_r;
  logic [CP_W-1:0]    acc_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [CP_W-1:0]    out_cp_r;
  logic               advance;
  step_res_t          step;

  // Move an item into the result register when it is free or being taken
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  utf8d_step u_step (
    .byte_i  (in_byte_r),
    .state_i (dfa_state_r),
    .acc_i   (acc_r),
    .res_o   (step)
  );

  // Advance the automaton once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfa_state_r <= ST_ACCEPT;
      acc_r       <= '0;
    end else if (advance) begin
      dfa_state_r <= step.state_nxt;
      acc_r       <= step.acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= step.status;
      out_cp_r     <= step.code_point;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cp_r};
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

/* test/utf8_stream_checker.sv */
// Checker for the UTF-8 byte stream decoder: watches both stream channels,
// predicts each result item and compares it with what comes out.
// Depends on utf8d_pkg for the status codes, widths and state constants.
`default_nettype none

module utf8_stream_checker
  import utf8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] in_byte
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // out_tdata: [20:0] code_point, [23:21] zero
  input  wire logic [23:0] out_tdata,
  // out_tuser: [1:0] status
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  output int               fail_count,
  output int               pending
);

  // Byte classes as they index the transition rows
  localparam logic [3:0] CL_ASCII    = 4'd0;
  localparam logic [3:0] CL_CONT_LO  = 4'd1;   // 80..8F
  localparam logic [3:0] CL_LEAD2    = 4'd2;   // C2..DF
  localparam logic [3:0] CL_LEAD3    = 4'd3;   // E1..EC, EE, EF
  localparam logic [3:0] CL_LEAD_ED  = 4'd4;
  localparam logic [3:0] CL_LEAD_F4  = 4'd5;
  localparam logic [3:0] CL_LEAD4    = 4'd6;   // F1..F3
  localparam logic [3:0] CL_CONT_HI  = 4'd7;   // A0..BF
  localparam logic [3:0] CL_BAD      = 4'd8;   // C0, C1, F5..FF
  localparam logic [3:0] CL_CONT_MID = 4'd9;   // 90..9F
  localparam logic [3:0] CL_LEAD_E0  = 4'd10;
  localparam logic [3:0] CL_LEAD_F0  = 4'd11;
  localparam int unsigned CLASS_COUNT = 12;

  typedef struct {
    status_t         status;
    logic [CP_W-1:0] cp;
  } decoded_t;

  decoded_t           decoded_q[$];
  logic [STATE_W-1:0] seq_state;
  logic [CP_W-1:0]    cp_acc;
  int unsigned        results_seen;

  // Map a raw byte to its class
  function automatic logic [3:0] byte_kind(input logic [7:0] b);
    if (b <= 8'h7F) return CL_ASCII;
    if (b <= 8'h8F) return CL_CONT_LO;
    if (b <= 8'h9F) return CL_CONT_MID;
    if (b <= 8'hBF) return CL_CONT_HI;
    if (b <= 8'hC1) return CL_BAD;
    if (b <= 8'hDF) return CL_LEAD2;
    if (b == 8'hE0) return CL_LEAD_E0;
    if (b == 8'hED) return CL_LEAD_ED;
    if (b <= 8'hEF) return CL_LEAD3;
    if (b == 8'hF0) return CL_LEAD_F0;
    if (b <= 8'hF3) return CL_LEAD4;
    if (b == 8'hF4) return CL_LEAD_F4;
    return CL_BAD;
  endfunction

  // Next automaton state; rows hold one nibble per class, class 11 on top
  function automatic logic [STATE_W-1:0] next_seq(input logic [STATE_W-1:0] st,
                                                 input logic [3:0] cls);
    logic [47:0] row;
    case (st)
      4'd0:    row = {4'd6, 4'd4, 4'd1, 4'd1, 4'd1, 4'd7, 4'd8, 4'd5, 4'd3, 4'd2, 4'd1, 4'd0};
      4'd2:    row = {4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1};
      4'd3:    row = {4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1};
      4'd4:    row = {4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1};
      4'd5:    row = {4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1};
      4'd6:    row = {4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1};
      4'd7:    row = {4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1};
      4'd8:    row = {4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1};
      default: row = {12{ST_REJECT}};
    endcase
    if (cls >= CLASS_COUNT) return ST_REJECT;
    return row[cls*4 +: 4];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    fail_count++;
  endtask

  // Advance the predicted decoder by one byte and queue its result
  task automatic decode_byte(input logic [7:0] b);
    logic [3:0]         cls;
    logic [STATE_W-1:0] nxt;
    decoded_t           d;
    cls = byte_kind(b);
    if (seq_state != ST_ACCEPT) begin
      cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
    end else begin
      cp_acc = CP_W'((LEAD_MASK >> cls) & b);
    end
    nxt = next_seq(seq_state, cls);
    if (nxt == ST_ACCEPT) begin
      seq_state = nxt;
      d.status = STAT_COMPLETE;
      d.cp = cp_acc;
    end else if (nxt == ST_REJECT) begin
      // drop the bad byte and restart from the accept state
      seq_state = ST_ACCEPT;
      cp_acc = '0;
      d.status = STAT_ERROR;
      d.cp = CP_REPLACEMENT;
    end else begin
      seq_state = nxt;
      d.status = STAT_INCOMPLETE;
      d.cp = '0;
    end
    decoded_q.push_back(d);
  endtask

  // Compare one result item with the oldest prediction
  task automatic check_result();
    decoded_t d;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, tuser %0d tdata %h",
                                out_tuser, out_tdata));
    end else begin
      d = decoded_q.pop_front();
      if (out_tuser !== d.status)
        report_mismatch($sformatf("status %0d, predicted %0d", out_tuser, d.status));
      if (out_tdata !== {3'b000, d.cp})
        report_mismatch($sformatf("tdata %h, predicted %h", out_tdata, {3'b000, d.cp}));
    end
    results_seen++;
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      seq_state = ST_ACCEPT;
      cp_acc = '0;
      decoded_q.delete();
      results_seen = 0;
      fail_count = 0;
      pending = 0;
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata);
      if (out_tvalid && out_tready) check_result();
      pending = decoded_q.size();
    end
  end

endmodule

`default_nettype wire

/* test/utf8_byte_stream_decoder_tb.sv */
// Testbench top for the UTF-8 byte stream decoder: clock, reset, byte
// stimulus, random back-pressure and the verdict.
// Depends on utf8d_pkg, utf8_byte_stream_decoder and utf8_stream_checker.
`default_nettype none

module utf8_byte_stream_decoder_tb;
  import utf8d_pkg::*;

  localparam int MAX_CYCLES   = 400000;
  localparam int RANDOM_BYTES = 900;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [7:0]  in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;

  int          fail_count;
  int          pending;
  int          bytes_sent = 0;
  int          cycles = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  logic [7:0]  seq_q[$];

  utf8_byte_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  utf8_stream_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle cycles before an item: none in quiet stretches, else short or long
  function automatic int unsigned pick_wait(input bit quiet);
    if (quiet) return 0;
    if ($urandom_range(0, 1) != 0) return $urandom_range(0, 19);
    return $urandom_range(0, 3);
  endfunction

  // Drive one byte from a falling edge and hold it until accepted
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_wait(send_quiet);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = b;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic push_seq();
    foreach (seq_q[i]) push_byte(seq_q[i]);
    seq_q.delete();
  endtask

  // Hold off the sender until every predicted result has come out
  task automatic drain_wait();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic void encode_cp(input int unsigned cp);
    if (cp < 32'h80) begin
      seq_q.push_back(8'(cp));
    end else if (cp < 32'h800) begin
      seq_q.push_back(8'(32'hC0 | (cp >> 6)));
      seq_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else if (cp < 32'h10000) begin
      seq_q.push_back(8'(32'hE0 | (cp >> 12)));
      seq_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      seq_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else begin
      seq_q.push_back(8'(32'hF0 | (cp >> 18)));
      seq_q.push_back(8'(32'h80 | ((cp >> 12) & 32'h3F)));
      seq_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      seq_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end
  endfunction

  // Random scalar value, spread evenly over the four encoded lengths
  function automatic int unsigned random_cp();
    int unsigned cp;
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(32'h0, 32'h7F);
      1: cp = $urandom_range(32'h80, 32'h7FF);
      2: begin
        do cp = $urandom_range(32'h800, 32'hFFFF);
        while (cp >= 32'hD800 && cp <= 32'hDFFF);
      end
      default: cp = $urandom_range(32'h10000, 32'h10FFFF);
    endcase
    return cp;
  endfunction

  // Lead byte that looks valid followed by a continuation out of its range, or C0/C1 with a continuation
  function automatic void queue_bad_pair();
    case ($urandom_range(0, 3))
      0: seq_q = '{8'(8'hC0 | $urandom_range(0, 1)), 8'(8'h80 | $urandom_range(0, 63))};
      1: seq_q = '{8'hE0, 8'(8'h80 | $urandom_range(0, 31)), 8'h80};
      2: seq_q = '{8'hED, 8'(8'hA0 | $urandom_range(0, 31)), 8'h80};
      default: seq_q = '{8'hF4, 8'(8'h90 | $urandom_range(0, 47)), 8'h80, 8'h80};
    endcase
  endfunction

  // Result side: random stalls, then ready until one item moves
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      stall = pick_wait(recv_quiet);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int start;
    int unsigned kind;
    int unsigned cut;
    bit paused;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    paused = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Boundaries of each length, NUL, and the common error shapes
    seq_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
              8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
              8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hC0,
              8'hED, 8'hA0, 8'hF4, 8'h90};
    push_seq();
    drain_wait();

    // Mostly well-formed text, some truncated sequences and raw noise
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
      if (!paused && bytes_sent - start >= RANDOM_BYTES / 2) begin
        drain_wait();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        encode_cp(random_cp());
      end else if (kind < 16) begin
        encode_cp(random_cp());
        if (seq_q.size() > 1) begin
          cut = $urandom_range(1, seq_q.size() - 1);
          while (seq_q.size() > cut) void'(seq_q.pop_back());
        end
        seq_q.push_back(8'($urandom));
      end else if (kind < 18) begin
        seq_q.push_back(8'($urandom));
      end else begin
        queue_bad_pair();
      end
      push_seq();
    end

    drain_wait();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes: length boundaries, NUL, overlong, surrogate and out-of-range",
             bytes_sent);
    $display("leads, then random well-formed, truncated and noise streams under back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
